// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the prescaler search block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while the active-low reset is asserted
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/bcps_pkg.sv =====
// ----------------------------------------------------------------------------
// bcps_pkg
// Widths, constants and shared types of the bus clock prescaler search.
// ----------------------------------------------------------------------------
package bcps_pkg;

    // Field widths of the item channels
    localparam int PCLK_W   = 20;
    localparam int TARGET_W = 16;
    localparam int BEST_P_W = 6;
    localparam int BEST_N_W = 3;
    localparam int RATE_W   = 16;

    // Search space
    localparam int MAX_PRESCALE   = 32;
    localparam int MAX_SHIFT_CODE = 7;
    localparam int PRE_W   = $clog2(MAX_PRESCALE + 1);
    localparam int SHIFT_W = (MAX_SHIFT_CODE > 0) ? $clog2(MAX_SHIFT_CODE + 1) : 1;

    // Divider base: 2^(n+2) + offset
    localparam int DIV_OFFSET = 16;
    localparam int BASE_MAX   = (1 << (MAX_SHIFT_CODE + 2)) + DIV_OFFSET;
    localparam int BASE_W     = $clog2(BASE_MAX + 1);
    localparam int DVS_W      = PRE_W + BASE_W;

    // Tick period window in ns
    localparam int TICK_SCALE  = 1000000;
    localparam int TICK_MIN_NS = 50;
    localparam int TICK_MAX_NS = 150;
    localparam int LIM_W  = PCLK_W + $clog2(TICK_MAX_NS + 2);
    localparam int NUM_W  = $clog2(MAX_PRESCALE * TICK_SCALE + 1);
    localparam int TCMP_W = (LIM_W > NUM_W) ? LIM_W : NUM_W;

    // Serial divider step counter
    localparam int DCNT_W = $clog2(PCLK_W);

    typedef struct packed {
        logic              start;
        logic [PCLK_W-1:0] dividend;
        logic [DVS_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [PCLK_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== design/bcps_if.sv =====
// ----------------------------------------------------------------------------
// bcps_if
// Valid/ready item channels of the prescaler search block.
// ----------------------------------------------------------------------------
interface bcps_in_if;
    import bcps_pkg::*;

    logic                valid;
    logic                ready;
    logic [PCLK_W-1:0]   pclk_rate_khz;
    logic [TARGET_W-1:0] target_rate_khz;

    modport source (output valid, pclk_rate_khz, target_rate_khz, input ready);
    modport sink   (input valid, pclk_rate_khz, target_rate_khz, output ready);
endinterface

interface bcps_out_if;
    import bcps_pkg::*;

    logic                valid;
    logic                ready;
    logic                found;
    logic [BEST_P_W-1:0] best_prescale;
    logic [BEST_N_W-1:0] best_shift_code;
    logic [RATE_W-1:0]   achieved_rate_khz;

    modport source (output valid, found, best_prescale, best_shift_code,
                    achieved_rate_khz, input ready);
    modport sink   (input valid, found, best_prescale, best_shift_code,
                    achieved_rate_khz, output ready);
endinterface

// ===== design/bcps_div.sv =====
// ----------------------------------------------------------------------------
// bcps_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bcps_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bcps_pkg::t_div_req i_req,
    output bcps_pkg::t_div_rsp o_rsp
);
    import bcps_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [PCLK_W-1:0] r_quo;

    logic [DVS_W:0]    trial;
    logic              fits;

    // Shift in the next dividend bit and try the subtraction
    assign trial = {r_rem, r_quo[PCLK_W-1]};
    assign fits  = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy) begin
                if (i_req.start) begin
                    r_busy <= 1'b1;
                    r_cnt  <= '0;
                    r_rem  <= '0;
                    r_dvs  <= i_req.divisor;
                    r_quo  <= i_req.dividend;
                end
            end else begin
                r_rem <= fits ? DVS_W'(trial - {1'b0, r_dvs}) : DVS_W'(trial);
                r_quo <= {r_quo[PCLK_W-2:0], fits};
                if (r_cnt == DCNT_W'(PCLK_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ===== design/bus_clock_prescaler_search_unit.sv =====
// ----------------------------------------------------------------------------
// bus_clock_prescaler_search_unit
// Finds the prescale and shift code that give the fastest serial clock
// not above a target rate.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one item: peripheral clock rate and target serial rate, kHz.
//   o_out returns one item per input: found flag, prescale, shift code and
//   the achieved rate (all zero when no pair fits).
//   i_in.ready is high only while the sequencer is idle; one item is searched
//   at a time. Each of the 32 prescale values gets a tick-window check; each
//   one inside the window then runs its 8 shift codes through a shared serial
//   divider (multiply, start, 20 divide steps, compare). The window holds at
//   most 22 prescales. A zero clock rate skips the search. Once the result
//   is handed over, the sequencer is idle and takes the next item.
//   The result sits in an output register until o_out.ready takes it, and
//   the next search runs meanwhile; a finished search waits only while that
//   register is still full.
//   Synchronous reset drops any search in progress and any pending result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bus_clock_prescaler_search_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bcps_in_if.sink           i_in,
    bcps_out_if.source        o_out
);
    import bcps_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_MUL,
        S_DIV,
        S_OUT
    } t_state;

    t_state              r_state,    n_state;
    logic [PCLK_W-1:0]   r_pclk,     n_pclk;
    logic [TARGET_W-1:0] r_target,   n_target;
    logic [TCMP_W-1:0]   r_lim_lo,   n_lim_lo;
    logic [TCMP_W-1:0]   r_lim_hi,   n_lim_hi;
    logic [PRE_W-1:0]    r_p,        n_p;
    logic [SHIFT_W-1:0]  r_n,        n_n;
    logic [DVS_W-1:0]    r_divisor,  n_divisor;
    logic                r_start,    n_start;
    logic [RATE_W-1:0]   r_best_rate, n_best_rate;
    logic [PRE_W-1:0]    r_best_p,   n_best_p;
    logic [SHIFT_W-1:0]  r_best_n,   n_best_n;
    logic                r_out_valid, n_out_valid;
    logic [RATE_W-1:0]   r_out_rate, n_out_rate;
    logic [PRE_W-1:0]    r_out_p,    n_out_p;
    logic [SHIFT_W-1:0]  r_out_n,    n_out_n;

    logic [TCMP_W-1:0]   tick_num;
    logic                tick_ok;
    logic [SHIFT_W:0]    shamt;
    logic [BASE_W-1:0]   base;
    logic [PCLK_W-1:0]   rate;
    logic                last_p;
    logic                last_n;
    logic                better;
    logic                out_stall;
    logic                out_empty;
    logic                best_fits;

    t_div_req            div_req;
    t_div_rsp            div_rsp;

    // Shared serial divider
    bcps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign div_req.start    = r_start;
    assign div_req.dividend = r_pclk;
    assign div_req.divisor  = r_divisor;

    // Tick window: 50 <= floor(p*1e6/pclk) <= 150, done without division
    assign tick_num = TCMP_W'(r_p) * TCMP_W'(TICK_SCALE);
    assign tick_ok  = (tick_num >= r_lim_lo) && (tick_num < r_lim_hi);

    // Divider base for the current shift code; shift amount one bit wider
    assign shamt  = {1'b0, r_n} + (SHIFT_W+1)'(2);
    assign base   = (BASE_W'(1) << shamt) + BASE_W'(DIV_OFFSET);
    assign rate   = div_rsp.quotient;
    assign better = (rate > PCLK_W'(r_best_rate)) && (rate <= PCLK_W'(r_target));
    assign last_p = (r_p == PRE_W'(MAX_PRESCALE));
    assign last_n = (r_n == SHIFT_W'(MAX_SHIFT_CODE));

    // Sequencer next state
    always_comb begin
        n_state     = r_state;
        n_pclk      = r_pclk;
        n_target    = r_target;
        n_lim_lo    = r_lim_lo;
        n_lim_hi    = r_lim_hi;
        n_p         = r_p;
        n_n         = r_n;
        n_divisor   = r_divisor;
        n_start     = 1'b0;
        n_best_rate = r_best_rate;
        n_best_p    = r_best_p;
        n_best_n    = r_best_n;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_rate  = r_out_rate;
        n_out_p     = r_out_p;
        n_out_n     = r_out_n;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_pclk      = i_in.pclk_rate_khz;
                    n_target    = i_in.target_rate_khz;
                    n_lim_lo    = TCMP_W'(i_in.pclk_rate_khz) * TCMP_W'(TICK_MIN_NS);
                    n_lim_hi    = TCMP_W'(i_in.pclk_rate_khz) * TCMP_W'(TICK_MAX_NS + 1);
                    n_p         = PRE_W'(1);
                    n_n         = '0;
                    n_best_rate = '0;
                    n_best_p    = '0;
                    n_best_n    = '0;
                    n_state     = (i_in.pclk_rate_khz == '0) ? S_OUT : S_TICK;
                end
            end
            S_TICK: begin
                if (tick_ok) begin
                    n_n     = '0;
                    n_state = S_MUL;
                end else if (last_p) begin
                    n_state = S_OUT;
                end else begin
                    n_p = r_p + 1'b1;
                end
            end
            S_MUL: begin
                n_divisor = DVS_W'(r_p) * DVS_W'(base);
                n_start   = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    if (better) begin
                        n_best_rate = RATE_W'(rate);
                        n_best_p    = r_p;
                        n_best_n    = r_n;
                    end
                    if (!last_n) begin
                        n_n     = r_n + 1'b1;
                        n_state = S_MUL;
                    end else if (last_p) begin
                        n_state = S_OUT;
                    end else begin
                        n_p     = r_p + 1'b1;
                        n_state = S_TICK;
                    end
                end
            end
            S_OUT: begin
                // hand the result to the output register once it is free
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_rate  = r_best_rate;
                    n_out_p     = r_best_p;
                    n_out_n     = r_best_n;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_start     <= n_start;
            r_out_valid <= n_out_valid;
        end
        r_pclk      <= n_pclk;
        r_target    <= n_target;
        r_lim_lo    <= n_lim_lo;
        r_lim_hi    <= n_lim_hi;
        r_p         <= n_p;
        r_n         <= n_n;
        r_divisor   <= n_divisor;
        r_best_rate <= n_best_rate;
        r_best_p    <= n_best_p;
        r_best_n    <= n_best_n;
        r_out_rate  <= n_out_rate;
        r_out_p     <= n_out_p;
        r_out_n     <= n_out_n;
    end

    // Channel outputs
    assign i_in.ready              = (r_state == S_IDLE);
    assign o_out.valid             = r_out_valid;
    assign o_out.found             = (r_out_rate != '0);
    assign o_out.best_prescale     = BEST_P_W'(r_out_p);
    assign o_out.best_shift_code   = BEST_N_W'(r_out_n);
    assign o_out.achieved_rate_khz = r_out_rate;

    // Terms for the checks
    assign out_stall = o_out.valid && !o_out.ready;
    assign out_empty = o_out.valid && !o_out.found;
    assign best_fits = (r_best_rate <= r_target);

    // Checks
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, out_stall |=> o_out.valid, "result dropped")
    `ASSERT_CLK(a_out_keep, i_clk, i_rst_n, out_stall |=> $stable(r_out_rate), "result changed")
    `ASSERT_CLK(a_empty_zero, i_clk, i_rst_n, out_empty |-> {r_out_p, r_out_n} == '0, "codes set")
    `ASSERT_CLK(a_best_fits, i_clk, i_rst_n, r_state == S_OUT |-> best_fits, "rate above target")
    `ASSERT_CLK(a_start_mul, i_clk, i_rst_n, r_start |-> $past(r_state) == S_MUL, "stray start")

endmodule
